### hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, quiet while reset is asserted.
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);

// Clocked check that must also hold during reset.
`define ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg)

`define ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

### hdl/opvd_pkg.sv
// Types, parameter codes and scaling constants for the OBD PID value decoder.
// No dependencies; imported by obd_pid_value_decoder_core.
`timescale 1ns / 1ps

package opvd_pkg;

    // Port widths
    localparam int S_DATA_W = 40;   // bytes A..E
    localparam int S_USER_W = 11;   // pid code, value index
    localparam int M_DATA_W = 48;   // scaled value padded to whole bytes

    localparam int VAL_W      = 46;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_W      = 32;
    localparam int QUO_W      = 30;
    localparam int RECIP_W    = 30;
    localparam int RECIP_SH   = 32;
    localparam int COEF_W     = 31;
    localparam int COEF_SHIFT = 18;
    localparam int FPROD_W    = 40;
    localparam int FRAC_W     = FPROD_W - COEF_SHIFT;

    localparam int PCT_SCALE    = 100;
    localparam int RAIL_SCALE   = 79;
    localparam int TRIM_STEP_Q  = 51200;   // 100/128 in Q.16

    typedef logic signed [VAL_W-1:0] val_t;

    // Value index selections
    localparam logic [2:0] IDX_SECOND = 3'd2;
    localparam logic [2:0] IDX_THIRD  = 3'd3;
    localparam logic [2:0] IDX_FOURTH = 3'd4;

    // Mode 01 parameter codes
    localparam logic [7:0] PID_ENGINE_LOAD       = 8'h04;
    localparam logic [7:0] PID_COOLANT_TEMP      = 8'h05;
    localparam logic [7:0] PID_LTFT_B1           = 8'h07;
    localparam logic [7:0] PID_STFT_B2           = 8'h08;
    localparam logic [7:0] PID_LTFT_B2           = 8'h09;
    localparam logic [7:0] PID_FUEL_PRESS        = 8'h0a;
    localparam logic [7:0] PID_INTAKE_MAP        = 8'h0b;
    localparam logic [7:0] PID_ENGINE_RPM        = 8'h0c;
    localparam logic [7:0] PID_VEHICLE_SPEED     = 8'h0d;
    localparam logic [7:0] PID_TIMING_ADV        = 8'h0e;
    localparam logic [7:0] PID_INTAKE_TEMP       = 8'h0f;
    localparam logic [7:0] PID_MAF_RATE          = 8'h10;
    localparam logic [7:0] PID_THROTTLE          = 8'h11;
    localparam logic [7:0] PID_O2_VOLT_FIRST     = 8'h14;
    localparam logic [7:0] PID_O2_VOLT_LAST      = 8'h1b;
    localparam logic [7:0] PID_RUN_TIME          = 8'h1f;
    localparam logic [7:0] PID_DIST_MIL          = 8'h21;
    localparam logic [7:0] PID_RAIL_PRESS_REL    = 8'h22;
    localparam logic [7:0] PID_RAIL_PRESS_GAUGE  = 8'h23;
    localparam logic [7:0] PID_O2_LAMBDA_V_FIRST = 8'h24;
    localparam logic [7:0] PID_O2_LAMBDA_V_LAST  = 8'h2b;
    localparam logic [7:0] PID_EGR_CMD           = 8'h2c;
    localparam logic [7:0] PID_EGR_ERROR         = 8'h2d;
    localparam logic [7:0] PID_EVAP_PURGE        = 8'h2e;
    localparam logic [7:0] PID_FUEL_LEVEL        = 8'h2f;
    localparam logic [7:0] PID_WARMUPS           = 8'h30;
    localparam logic [7:0] PID_DIST_CLEAR        = 8'h31;
    localparam logic [7:0] PID_EVAP_VAPOR        = 8'h32;
    localparam logic [7:0] PID_BARO              = 8'h33;
    localparam logic [7:0] PID_O2_LAMBDA_I_FIRST = 8'h34;
    localparam logic [7:0] PID_O2_LAMBDA_I_LAST  = 8'h3b;
    localparam logic [7:0] PID_CAT_TEMP_FIRST    = 8'h3c;
    localparam logic [7:0] PID_CAT_TEMP_LAST     = 8'h3f;
    localparam logic [7:0] PID_MODULE_VOLT       = 8'h42;
    localparam logic [7:0] PID_ABS_LOAD          = 8'h43;
    localparam logic [7:0] PID_LAMBDA_CMD        = 8'h44;
    localparam logic [7:0] PID_REL_THROTTLE      = 8'h45;
    localparam logic [7:0] PID_AMBIENT_TEMP      = 8'h46;
    localparam logic [7:0] PID_PEDAL_FIRST       = 8'h47;
    localparam logic [7:0] PID_PEDAL_LAST        = 8'h4c;
    localparam logic [7:0] PID_TIME_MIL          = 8'h4d;
    localparam logic [7:0] PID_TIME_CLEAR        = 8'h4e;
    localparam logic [7:0] PID_MAX_VALUES        = 8'h4f;
    localparam logic [7:0] PID_MAF_MAX           = 8'h50;
    localparam logic [7:0] PID_ETHANOL           = 8'h52;
    localparam logic [7:0] PID_EVAP_ABS          = 8'h53;
    localparam logic [7:0] PID_EVAP_SYS          = 8'h54;
    localparam logic [7:0] PID_SEC_O2_FIRST      = 8'h55;
    localparam logic [7:0] PID_SEC_O2_LAST       = 8'h58;
    localparam logic [7:0] PID_RAIL_PRESS_ABS    = 8'h59;
    localparam logic [7:0] PID_REL_PEDAL         = 8'h5a;
    localparam logic [7:0] PID_HYBRID_BATT       = 8'h5b;
    localparam logic [7:0] PID_OIL_TEMP          = 8'h5c;
    localparam logic [7:0] PID_INJ_TIMING        = 8'h5d;
    localparam logic [7:0] PID_FUEL_RATE         = 8'h5e;
    localparam logic [7:0] PID_TORQUE_DEMAND     = 8'h61;
    localparam logic [7:0] PID_TORQUE_ACTUAL     = 8'h62;
    localparam logic [7:0] PID_TORQUE_REF        = 8'h63;
    localparam logic [7:0] PID_MAF_SENSOR        = 8'h66;
    localparam logic [7:0] PID_COOLANT_TEMP2     = 8'h67;
    localparam logic [7:0] PID_INTAKE_TEMP2      = 8'h68;
    localparam logic [7:0] PID_DPF_TEMP          = 8'h7c;
    localparam logic [7:0] PID_TORQUE_FRICTION   = 8'h8e;
    localparam logic [7:0] PID_CYL_FUEL_RATE     = 8'ha2;
    localparam logic [7:0] PID_GEAR              = 8'ha4;
    localparam logic [7:0] PID_DEF_DOSING        = 8'ha5;
    localparam logic [7:0] PID_ODOMETER          = 8'ha6;
    localparam logic [7:0] PID_ABS_SWITCH        = 8'ha9;

    // Ratio class: result = round(num * 2^k / d), d odd
    typedef enum logic [2:0] {
        DIV_25_K13,
        DIV_125_K13,
        DIV_25_K14,
        DIV_5_K14,
        DIV_5_K15,
        DIV_255_K16
    } div_cls_t;

    typedef struct packed {
        logic [7:0] pid;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] e;
        logic [2:0] idx;
    } in_t;

    typedef struct packed {
        logic             unknown;
        val_t             base;
        logic [NUM_W-1:0] num;
        div_cls_t         cls;
    } dec_t;

    typedef struct packed {
        logic             unknown;
        val_t             base;
        logic [NUM_W-1:0] num;
        div_cls_t         cls;
        logic [QUO_W-1:0] q;
    } quo_t;

    typedef struct packed {
        logic             unknown;
        val_t             base;
        div_cls_t         cls;
        logic [QUO_W-1:0] q;
        logic [7:0]       r;
    } rem_t;

    typedef struct packed {
        logic unknown;
        val_t value;
    } out_t;

    function automatic logic [7:0] div_of(input div_cls_t cls);
        case (cls)
            DIV_25_K13:  return 8'd25;
            DIV_125_K13: return 8'd125;
            DIV_25_K14:  return 8'd25;
            DIV_5_K14:   return 8'd5;
            DIV_5_K15:   return 8'd5;
            DIV_255_K16: return 8'd255;
            default:     return 8'd5;
        endcase
    endfunction

    // floor(2^32 / d): quotient estimate low by at most one
    function automatic logic [RECIP_W-1:0] recip_of(input div_cls_t cls);
        case (cls)
            DIV_25_K13:  return RECIP_W'(171798691);
            DIV_125_K13: return RECIP_W'(34359738);
            DIV_25_K14:  return RECIP_W'(171798691);
            DIV_5_K14:   return RECIP_W'(858993459);
            DIV_5_K15:   return RECIP_W'(858993459);
            DIV_255_K16: return RECIP_W'(16843009);
            default:     return RECIP_W'(858993459);
        endcase
    endfunction

    // floor(2^(k+18) / d): turns a remainder into rounded fraction steps
    function automatic logic [COEF_W-1:0] frac_coef(input div_cls_t cls);
        case (cls)
            DIV_25_K13:  return COEF_W'(85899345);
            DIV_125_K13: return COEF_W'(17179869);
            DIV_25_K14:  return COEF_W'(171798691);
            DIV_5_K14:   return COEF_W'(858993459);
            DIV_5_K15:   return COEF_W'(1717986918);
            DIV_255_K16: return COEF_W'(67372036);
            default:     return COEF_W'(1717986918);
        endcase
    endfunction

    function automatic logic [4:0] frac_shift(input div_cls_t cls);
        case (cls)
            DIV_25_K13:  return 5'd13;
            DIV_125_K13: return 5'd13;
            DIV_25_K14:  return 5'd14;
            DIV_5_K14:   return 5'd14;
            DIV_5_K15:   return 5'd15;
            DIV_255_K16: return 5'd16;
            default:     return 5'd15;
        endcase
    endfunction

    function automatic val_t ext(input logic [31:0] x);
        return val_t'({{(VAL_W - 32){1'b0}}, x});
    endfunction

    function automatic val_t q_int(input val_t x);
        return x <<< FRAC_BITS;
    endfunction

endpackage

### hdl/obd_pid_value_decoder_core.sv
// OBD-II mode 01 parameter value decoder, five-register pipeline.
// Depends on opvd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Decodes one mode 01 response beat (parameter code, bytes A..E, value index) into the
// physical value as signed Q.16, rounded to nearest, with m_tuser set and the value zero
// for codes that have no formula. One beat is accepted every cycle while s_tready is high; the
// pipeline is input register, code decode, reciprocal multiply for the constant divisor,
// remainder correction, then fraction multiply and final sum into the output register.
// Stages hold independently, so empty slots keep accepting while a finished result waits
// on m_tready.
module obd_pid_value_decoder_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [opvd_pkg::S_DATA_W-1:0]  s_tdata,   // byte_a, byte_b, byte_c, byte_d, byte_e
    input  logic [opvd_pkg::S_USER_W-1:0]  s_tuser,   // pid_code, value_index
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [opvd_pkg::M_DATA_W-1:0]  m_tdata,   // scaled_value, zero pad
    output logic                           m_tuser    // unknown_code
);
    import opvd_pkg::*;

    in_t   in_reg;
    dec_t  dec_reg,  dec_next;
    quo_t  quo_reg,  quo_next;
    rem_t  rem_reg,  rem_next;
    out_t  out_reg,  out_next;
    logic  in_vld_reg, dec_vld_reg, quo_vld_reg, rem_vld_reg, out_vld_reg;
    logic  in_rdy, dec_rdy, quo_rdy, rem_rdy, out_rdy;

    logic [15:0]          ab, bc, cd, de;
    logic [31:0]          abcd;
    logic                 second;
    val_t                 va, vb, vc, vd, vab, vbc, vcd, vde;
    logic [2*NUM_W-3:0]   recip_prod;
    logic [NUM_W-1:0]     rem_full;
    logic [8:0]           rem_est;
    logic [8:0]           rem_div;
    logic [FPROD_W-1:0]   frac_prod;
    logic [FRAC_W-1:0]    frac;

    // ------------------------------------------------------------------
    // Flow control: each stage loads when empty or when its successor moves
    // ------------------------------------------------------------------
    assign out_rdy  = !out_vld_reg || m_tready;
    assign rem_rdy  = !rem_vld_reg || out_rdy;
    assign quo_rdy  = !quo_vld_reg || rem_rdy;
    assign dec_rdy  = !dec_vld_reg || quo_rdy;
    assign in_rdy   = !in_vld_reg  || dec_rdy;
    assign s_tready = in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            dec_vld_reg <= 1'b0;
            quo_vld_reg <= 1'b0;
            rem_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_rdy)
                in_vld_reg <= s_tvalid;
            if (dec_rdy)
                dec_vld_reg <= in_vld_reg;
            if (quo_rdy)
                quo_vld_reg <= dec_vld_reg;
            if (rem_rdy)
                rem_vld_reg <= quo_vld_reg;
            if (out_rdy)
                out_vld_reg <= rem_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && s_tvalid)
        begin
            in_reg.a   <= s_tdata[7:0];
            in_reg.b   <= s_tdata[15:8];
            in_reg.c   <= s_tdata[23:16];
            in_reg.d   <= s_tdata[31:24];
            in_reg.e   <= s_tdata[39:32];
            in_reg.pid <= s_tuser[7:0];
            in_reg.idx <= s_tuser[10:8];
        end
        if (dec_rdy && in_vld_reg)
            dec_reg <= dec_next;
        if (quo_rdy && dec_vld_reg)
            quo_reg <= quo_next;
        if (rem_rdy && quo_vld_reg)
            rem_reg <= rem_next;
        if (out_rdy && rem_vld_reg)
            out_reg <= out_next;
    end

    // ------------------------------------------------------------------
    // Decode: exact formulas land in base; ratios leave num and a divisor class
    // ------------------------------------------------------------------
    assign ab     = {in_reg.a, in_reg.b};
    assign bc     = {in_reg.b, in_reg.c};
    assign cd     = {in_reg.c, in_reg.d};
    assign de     = {in_reg.d, in_reg.e};
    assign abcd   = {in_reg.a, in_reg.b, in_reg.c, in_reg.d};
    assign second = (in_reg.idx == IDX_SECOND);
    assign va     = ext(32'(in_reg.a));
    assign vb     = ext(32'(in_reg.b));
    assign vc     = ext(32'(in_reg.c));
    assign vd     = ext(32'(in_reg.d));
    assign vab    = ext(32'(ab));
    assign vbc    = ext(32'(bc));
    assign vcd    = ext(32'(cd));
    assign vde    = ext(32'(de));

    always_comb
    begin
        dec_next.unknown = 1'b0;
        dec_next.base    = '0;
        dec_next.num     = '0;
        dec_next.cls     = DIV_5_K15;
        case (in_reg.pid) inside
            PID_TORQUE_DEMAND, PID_TORQUE_ACTUAL, PID_TORQUE_FRICTION:
                dec_next.base = q_int(va - val_t'(125));
            PID_COOLANT_TEMP, PID_INTAKE_TEMP, PID_AMBIENT_TEMP, PID_OIL_TEMP:
                dec_next.base = q_int(va - val_t'(40));
            PID_MAF_MAX:
                dec_next.base = q_int(va * val_t'(10));
            [PID_O2_VOLT_FIRST:PID_O2_VOLT_LAST]:
            begin
                if (second)
                    dec_next.base = vb * val_t'(TRIM_STEP_Q) - q_int(val_t'(100));
                else
                begin
                    dec_next.num = 32'(in_reg.a);
                    dec_next.cls = DIV_25_K13;
                end
            end
            PID_TIMING_ADV:
                dec_next.base = (va <<< (FRAC_BITS - 1)) - q_int(val_t'(64));
            PID_ODOMETER:
            begin
                dec_next.num = abcd;
                dec_next.cls = DIV_5_K15;
            end
            PID_MAX_VALUES:
            begin
                if (in_reg.idx == IDX_SECOND)
                    dec_next.base = q_int(vb);
                else if (in_reg.idx == IDX_THIRD)
                    dec_next.base = q_int(vc);
                else if (in_reg.idx == IDX_FOURTH)
                    dec_next.base = q_int(vd * val_t'(10));
                else
                    dec_next.base = q_int(va);
            end
            PID_INTAKE_MAP, PID_VEHICLE_SPEED, PID_WARMUPS, PID_BARO:
                dec_next.base = q_int(va);
            PID_EVAP_SYS, PID_RUN_TIME, PID_DIST_MIL, PID_DIST_CLEAR,
            PID_TIME_MIL, PID_TIME_CLEAR, PID_TORQUE_REF:
                dec_next.base = q_int(vab);
            PID_MODULE_VOLT:
            begin
                dec_next.num = 32'(ab);
                dec_next.cls = DIV_125_K13;
            end
            PID_EVAP_ABS:
            begin
                dec_next.num = 32'(ab);
                dec_next.cls = DIV_25_K13;
            end
            PID_INJ_TIMING:
                dec_next.base = (vab <<< (FRAC_BITS - 7)) - q_int(val_t'(210));
            PID_MAF_RATE:
            begin
                dec_next.num = 32'(ab);
                dec_next.cls = DIV_25_K14;
            end
            PID_CYL_FUEL_RATE:
                dec_next.base = vab <<< (FRAC_BITS - 5);
            PID_FUEL_RATE:
            begin
                dec_next.num = 32'(ab);
                dec_next.cls = DIV_5_K14;
            end
            [PID_CAT_TEMP_FIRST:PID_CAT_TEMP_LAST], PID_DPF_TEMP:
            begin
                dec_next.num  = 32'(ab);
                dec_next.cls  = DIV_5_K15;
                dec_next.base = -q_int(val_t'(40));
            end
            PID_EVAP_VAPOR:
                dec_next.base = val_t'(signed'(ab)) <<< (FRAC_BITS - 2);
            PID_ENGINE_RPM:
                dec_next.base = vab <<< (FRAC_BITS - 2);
            [PID_PEDAL_FIRST:PID_PEDAL_LAST], PID_ENGINE_LOAD, PID_THROTTLE,
            PID_EGR_CMD, PID_EVAP_PURGE, PID_FUEL_LEVEL, PID_REL_THROTTLE,
            PID_ETHANOL, PID_REL_PEDAL, PID_HYBRID_BATT:
            begin
                dec_next.num = 32'(in_reg.a) * 32'(PCT_SCALE);
                dec_next.cls = DIV_255_K16;
            end
            PID_LTFT_B1, PID_STFT_B2, PID_LTFT_B2, PID_EGR_ERROR:
                dec_next.base = va * val_t'(TRIM_STEP_Q) - q_int(val_t'(100));
            [PID_SEC_O2_FIRST:PID_SEC_O2_LAST]:
                dec_next.base = (second ? vb : va) * val_t'(TRIM_STEP_Q)
                                - q_int(val_t'(100));
            PID_ABS_LOAD:
            begin
                dec_next.num = 32'(ab) * 32'(PCT_SCALE);
                dec_next.cls = DIV_255_K16;
            end
            PID_RAIL_PRESS_GAUGE, PID_RAIL_PRESS_ABS:
                dec_next.base = q_int(vab * val_t'(10));
            PID_FUEL_PRESS:
                dec_next.base = q_int(va * val_t'(3));
            [PID_O2_LAMBDA_V_FIRST:PID_O2_LAMBDA_V_LAST]:
                dec_next.base = second ? (vcd <<< 3) : (vab <<< 1);
            [PID_O2_LAMBDA_I_FIRST:PID_O2_LAMBDA_I_LAST]:
                dec_next.base = second ? ((vcd <<< 8) - q_int(val_t'(128))) : (vab <<< 1);
            PID_LAMBDA_CMD:
                dec_next.base = vab <<< 1;
            PID_RAIL_PRESS_REL:
            begin
                dec_next.num = 32'(ab) * 32'(RAIL_SCALE);
                dec_next.cls = DIV_125_K13;
            end
            PID_GEAR:
            begin
                dec_next.num = 32'(cd);
                dec_next.cls = DIV_125_K13;
            end
            PID_MAF_SENSOR:
                dec_next.base = second ? (vde <<< (FRAC_BITS - 5)) : (vbc <<< (FRAC_BITS - 5));
            PID_COOLANT_TEMP2, PID_INTAKE_TEMP2:
                dec_next.base = q_int((second ? vc : vb) - val_t'(40));
            PID_ABS_SWITCH:
                dec_next.base = q_int(val_t'(in_reg.b[0]));
            PID_DEF_DOSING:
                dec_next.base = vb <<< (FRAC_BITS - 1);
            default:
                dec_next.unknown = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Quotient estimate: num * floor(2^32/d) >> 32, low by at most one
    // ------------------------------------------------------------------
    assign recip_prod = (2*NUM_W-2)'(dec_reg.num) * (2*NUM_W-2)'(recip_of(dec_reg.cls));

    always_comb
    begin
        quo_next.unknown = dec_reg.unknown;
        quo_next.base    = dec_reg.base;
        quo_next.num     = dec_reg.num;
        quo_next.cls     = dec_reg.cls;
        quo_next.q       = recip_prod[RECIP_SH +: QUO_W];
    end

    // ------------------------------------------------------------------
    // Remainder and one correction step
    // ------------------------------------------------------------------
    assign rem_full = quo_reg.num - NUM_W'(quo_reg.q) * NUM_W'(div_of(quo_reg.cls));
    assign rem_est  = rem_full[8:0];
    assign rem_div  = 9'(div_of(quo_reg.cls));

    always_comb
    begin
        rem_next.unknown = quo_reg.unknown;
        rem_next.base    = quo_reg.base;
        rem_next.cls     = quo_reg.cls;
        if (rem_est >= rem_div)
        begin
            rem_next.q = quo_reg.q + QUO_W'(1);
            rem_next.r = 8'(rem_est - rem_div);
        end
        else
        begin
            rem_next.q = quo_reg.q;
            rem_next.r = rem_est[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Rounded fraction of r/d, then q * 2^k + fraction + offset
    // ------------------------------------------------------------------
    assign frac_prod = FPROD_W'(rem_reg.r) * FPROD_W'(frac_coef(rem_reg.cls))
                       + FPROD_W'(1 << (COEF_SHIFT - 1));
    assign frac      = frac_prod[FPROD_W-1:COEF_SHIFT];

    always_comb
    begin
        out_next.unknown = rem_reg.unknown;
        out_next.value   = rem_reg.base
                           + (ext(32'(rem_reg.q)) <<< frac_shift(rem_reg.cls))
                           + ext(32'(frac));
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_DATA_W - VAL_W){1'b0}}, out_reg.value};
    assign m_tuser  = out_reg.unknown;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_unknown_gives_zero, clk, rst_n, m_tvalid && m_tuser |-> m_tdata == '0, "unknown code with nonzero value")
    `ASSERT_CLK(a_rem_below_div, clk, rst_n, rem_vld_reg |-> 9'(rem_reg.r) < 9'(div_of(rem_reg.cls)), "remainder not reduced below divisor")
    `ASSERT_CLK(a_unknown_clean, clk, rst_n, dec_vld_reg && dec_reg.unknown |-> dec_reg.num == '0 && dec_reg.base == '0, "unknown code carries a value")
    `ASSERT_ALWAYS(a_stall_only_full, clk, !s_tready |-> in_vld_reg && dec_vld_reg && quo_vld_reg && rem_vld_reg && out_vld_reg, "input stalled with an empty stage")

endmodule
